// ===== design/dual_stack_shared_memory_macros.svh =====
// Assertion macros for the dual stack shared memory block.
// Used by the top level; needs a signal named clock and one named reset in scope.
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define DSSM_CHECK(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define DSSM_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that implies another in the following cycle.
`define DSSM_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dssm_pkg.sv =====
// Package for the dual stack shared memory block: sizes, codes and payload types.
// Has no dependencies; every other file of the block but the assertion macro header imports it.
package dssm_pkg;

   localparam int MEM_DEPTH = 64;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
   localparam int CFG_W     = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W    = $clog2(QUEUE_DEPTH + 1);

   // Commands.
   localparam logic [2:0] CMD_PUSH_ONE = 3'd0;
   localparam logic [2:0] CMD_PUSH_TWO = 3'd1;
   localparam logic [2:0] CMD_POP_ONE  = 3'd2;
   localparam logic [2:0] CMD_POP_TWO  = 3'd3;
   localparam logic [2:0] CMD_LIST_ONE = 3'd4;
   localparam logic [2:0] CMD_LIST_TWO = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   // Kinds of work handed from the front to the back.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_LIST   = 2'd2;

   // Register index of the capacity register.
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] elem_value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [31:0]       value;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  count;
      logic              up;
   } op_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_one;
      logic [CNT_W-1:0] count_two;
   } counts_type;

endpackage

// ===== design/dssm_front.sv =====
// Front end of the dual stack shared memory: accepts requests, keeps both
// stack counts and turns each request with a known command into an operation for the back end. Uses dssm_pkg.
module dssm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dssm_pkg::req_type          req_payload,
   input  logic [dssm_pkg::CNT_W-1:0] capacity,
   input  logic                       cfg_clear,
   input  logic                       q_full,
   output logic                       q_push,
   output dssm_pkg::op_type           q_data,
   output dssm_pkg::counts_type       counts
);
   import dssm_pkg::*;

   logic [CNT_W-1:0] count_one_ff, count_one_in;
   logic [CNT_W-1:0] count_two_ff, count_two_in;
   logic [CNT_W:0]   count_sum;
   logic             room;
   logic             accept;
   logic             cmd_known;
   logic [CNT_W-1:0] slot_push_two;
   logic [CNT_W-1:0] slot_top_one;
   logic [CNT_W-1:0] slot_top_two;

   assign accept    = start && !q_full;
   assign busy      = q_full;
   assign count_sum = {1'b0, count_one_ff} + {1'b0, count_two_ff};
   assign room      = count_sum < {1'b0, capacity};

   assign slot_push_two = capacity - CNT_W'(1) - count_two_ff;
   assign slot_top_one  = count_one_ff - CNT_W'(1);
   assign slot_top_two  = capacity - count_two_ff;

   always_comb begin
      count_one_in = count_one_ff;
      count_two_in = count_two_ff;
      cmd_known    = 1'b1;
      q_data.kind   = KIND_STATUS;
      q_data.status = ST_OK;
      q_data.value  = req_payload.push_value;
      q_data.addr   = count_one_ff[ADDR_W-1:0];
      q_data.count  = count_one_ff;
      q_data.up     = 1'b0;
      case (req_payload.cmd)
         CMD_PUSH_ONE: begin
            if (room) begin
               q_data.kind  = KIND_WRITE;
               count_one_in = count_one_ff + CNT_W'(1);
            end else begin
               q_data.status = ST_OVERFLOW;
            end
         end
         CMD_PUSH_TWO: begin
            q_data.addr = slot_push_two[ADDR_W-1:0];
            if (room) begin
               q_data.kind  = KIND_WRITE;
               count_two_in = count_two_ff + CNT_W'(1);
            end else begin
               q_data.status = ST_OVERFLOW;
            end
         end
         CMD_POP_ONE: begin
            if (count_one_ff == '0) begin
               q_data.status = ST_EMPTY;
            end else begin
               count_one_in = count_one_ff - CNT_W'(1);
            end
         end
         CMD_POP_TWO: begin
            if (count_two_ff == '0) begin
               q_data.status = ST_EMPTY;
            end else begin
               count_two_in = count_two_ff - CNT_W'(1);
            end
         end
         CMD_LIST_ONE: begin
            q_data.addr = slot_top_one[ADDR_W-1:0];
            if (count_one_ff == '0) begin
               q_data.status = ST_EMPTY;
            end else begin
               q_data.kind = KIND_LIST;
            end
         end
         CMD_LIST_TWO: begin
            q_data.addr  = slot_top_two[ADDR_W-1:0];
            q_data.count = count_two_ff;
            q_data.up    = 1'b1;
            if (count_two_ff == '0) begin
               q_data.status = ST_EMPTY;
            end else begin
               q_data.kind = KIND_LIST;
            end
         end
         default: begin
            cmd_known = 1'b0;
         end
      endcase
   end

   assign q_push = accept && cmd_known;

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         count_one_ff <= '0;
         count_two_ff <= '0;
      end else if (accept) begin
         count_one_ff <= count_one_in;
         count_two_ff <= count_two_in;
      end
   end

   assign counts.count_one = count_one_ff;
   assign counts.count_two = count_two_ff;

endmodule

// ===== design/dssm_queue.sv =====
// Two-entry operation queue between the front and back ends.
// Uses dssm_pkg for the entry type and its depth.
module dssm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dssm_pkg::op_type push_data,
   input  logic             pop,
   output dssm_pkg::op_type pop_data,
   output logic             full,
   output logic             empty
);
   import dssm_pkg::*;

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   assign full     = level_ff == QLVL_W'(QUEUE_DEPTH);
   assign empty    = level_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/dssm_back.sv =====
// Back end of the dual stack shared memory: holds the slot memory, performs
// writes and streams list reads and status results into the result register. Uses dssm_pkg.
module dssm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  dssm_pkg::op_type  q_data,
   output logic              q_pop,
   output logic              rsp_strobe,
   output dssm_pkg::rsp_type rsp_payload
);
   import dssm_pkg::*;

   logic [31:0]       mem [MEM_DEPTH];
   logic [31:0]       rd_data_ff;

   logic              active_ff, active_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              up_ff, up_in;

   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_status_ff, out_status_in;
   logic              out_last_ff, out_last_in;
   logic              out_elem_ff, out_elem_in;

   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_remain;
   logic              rd_up;
   logic              do_read;
   logic              do_write;

   assign q_pop     = !active_ff && !q_empty;
   assign rd_addr   = active_ff ? addr_ff : q_data.addr;
   assign rd_remain = active_ff ? remain_ff : q_data.count;
   assign rd_up     = active_ff ? up_ff : q_data.up;

   always_comb begin
      do_read  = active_ff;
      do_write = 1'b0;
      if (q_pop) begin
         case (q_data.kind)
            KIND_WRITE: do_write = 1'b1;
            KIND_LIST:  do_read  = 1'b1;
            default:    do_read  = 1'b0;
         endcase
      end
   end

   // A list walks down from the top of stack one, or up from the top of stack two.
   always_comb begin
      active_in = do_read && (rd_remain != CNT_W'(1));
      addr_in   = rd_up ? rd_addr + ADDR_W'(1) : rd_addr - ADDR_W'(1);
      remain_in = rd_remain - CNT_W'(1);
      up_in     = rd_up;

      out_valid_in  = active_ff || q_pop;
      out_elem_in   = do_read;
      out_status_in = do_read ? ST_OK : q_data.status;
      out_last_in   = do_read ? (rd_remain == CNT_W'(1)) : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      remain_ff     <= remain_in;
      up_ff         <= up_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      out_elem_ff   <= out_elem_in;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[q_data.addr] <= q_data.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe             = out_valid_ff;
   assign rsp_payload.status     = out_status_ff;
   assign rsp_payload.elem_value = out_elem_ff ? rd_data_ff : '0;
   assign rsp_payload.last       = out_last_ff;

endmodule

// ===== design/dual_stack_shared_memory.sv =====
// Two stacks in one 64-slot memory. A push or pop gives its single result through the queue
// and the back end's result register; a list of n elements gives n results, one per cycle.
// Pushes and pops sustain one request per cycle while no list holds the memory read port; a
// list holds it until its last element is read; busy rises once the two-entry queue fills.
// Reset clears both stacks, sets the capacity to 64 and leaves memory contents undefined.
`include "dual_stack_shared_memory_macros.svh"

module dual_stack_shared_memory (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dssm_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output dssm_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import dssm_pkg::*;

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CFG_W-1:0] wr_value;
   logic             cfg_write;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   op_type           front_op;
   op_type           back_op;
   counts_type       counts;
   logic [CNT_W:0]   count_sum;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
   assign wr_value  = pwdata[CFG_W-1:0];

   // The low seven bits of pwdata are clamped to the legal range of 1 to MEM_DEPTH; higher bits are ignored.
   always_comb begin
      if (wr_value == '0) begin
         cap_in = CNT_W'(1);
      end else if (wr_value > CFG_W'(MEM_DEPTH)) begin
         cap_in = CNT_W'(MEM_DEPTH);
      end else begin
         cap_in = CNT_W'(wr_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CNT_W'(MEM_DEPTH);
      end else if (cfg_write) begin
         cap_ff <= cap_in;
      end
   end

   assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_ff) : '0;

   dssm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .capacity    (cap_ff),
      .cfg_clear   (cfg_write),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (front_op),
      .counts      (counts)
   );

   dssm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_op),
      .pop       (q_pop),
      .pop_data  (back_op),
      .full      (q_full),
      .empty     (q_empty)
   );

   dssm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_data      (back_op),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   assign count_sum = {1'b0, counts.count_one} + {1'b0, counts.count_two};

   `DSSM_CHECK(a_stacks_fit, count_sum <= {1'b0, cap_ff}, "stacks overlap in memory")
   `DSSM_CHECK(a_cap_range, cap_ff != '0 && cap_ff <= CNT_W'(MEM_DEPTH), "capacity out of range")
   `DSSM_IMPLY(a_err_last, rsp_strobe && rsp_payload.status != ST_OK, rsp_payload.last, "error not last")
   `DSSM_NEXT(a_cfg_clears, cfg_write, count_sum == '0, "capacity write left stacks filled")

endmodule

// ===== tb/sv/dual_stack_shared_memory_tb.sv =====
// Testbench for the two-stacks-in-one-memory block: directed and random push, pop and list
// requests checked against an internal prediction of both stacks and the capacity register.
// Depends on dssm_pkg and the dual_stack_shared_memory top level only.
`timescale 1ns / 100ps

module dual_stack_shared_memory_tb;
   import dssm_pkg::*;

   localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
   localparam logic [2:0] CMD_SPARE_LOW  = 3'd6;
   localparam logic [2:0] CMD_SPARE_HIGH = 3'd7;
   localparam int DRAIN_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_payload = '0;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Predicted contents of the two stacks.
   logic [31:0] stack_slots [MEM_DEPTH];
   int          depth_one = 0;
   int          depth_two = 0;
   int          capacity = MEM_DEPTH;

   rsp_type     expected_results[$];
   int          mismatch_count = 0;

   dual_stack_shared_memory uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic rsp_type make_result(logic [1:0] status, logic [31:0] value,
                                           logic last);
      rsp_type r;
      r.status = status;
      r.elem_value = value;
      r.last = last;
      return r;
   endfunction

   // Works out the results of one accepted request and updates the stacks.
   function automatic void predict_stack_op(req_type item);
      int slot;
      case (item.cmd)
         CMD_PUSH_ONE, CMD_PUSH_TWO: begin
            if (depth_one + depth_two >= capacity) begin
               expected_results.push_back(make_result(ST_OVERFLOW, '0, 1'b1));
            end else begin
               if (item.cmd == CMD_PUSH_ONE) begin
                  stack_slots[depth_one] = item.push_value;
                  depth_one++;
               end else begin
                  stack_slots[capacity - 1 - depth_two] = item.push_value;
                  depth_two++;
               end
               expected_results.push_back(make_result(ST_OK, '0, 1'b1));
            end
         end
         CMD_POP_ONE: begin
            if (depth_one == 0) begin
               expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            end else begin
               depth_one--;
               expected_results.push_back(make_result(ST_OK, '0, 1'b1));
            end
         end
         CMD_POP_TWO: begin
            if (depth_two == 0) begin
               expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            end else begin
               depth_two--;
               expected_results.push_back(make_result(ST_OK, '0, 1'b1));
            end
         end
         CMD_LIST_ONE: begin
            if (depth_one == 0) begin
               expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            end
            for (slot = depth_one - 1; slot >= 0; slot--) begin
               expected_results.push_back(make_result(ST_OK, stack_slots[slot], slot == 0));
            end
         end
         CMD_LIST_TWO: begin
            if (depth_two == 0) begin
               expected_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            end
            for (slot = capacity - depth_two; slot < capacity; slot++) begin
               expected_results.push_back(make_result(ST_OK, stack_slots[slot],
                                                      slot + 1 == capacity));
            end
         end
         default: ;
      endcase
   endfunction

   // Every result strobe is compared against the oldest pending expectation.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d elem=%0d last=%0d", $time,
                     rsp_payload.status, rsp_payload.elem_value, rsp_payload.last);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.status !== want.status || rsp_payload.elem_value !== want.elem_value
                || rsp_payload.last !== want.last) begin
               $display({"%0t: expected status=%0d elem=%0d last=%0d, ",
                         "actual status=%0d elem=%0d last=%0d"},
                        $time, want.status, want.elem_value, want.last, rsp_payload.status,
                        rsp_payload.elem_value, rsp_payload.last);
               mismatch_count++;
            end
         end
      end
   end

   // Called at a rising edge; returns at the edge that accepts the request, start still high.
   task automatic send_request(logic [2:0] cmd, logic [31:0] value);
      req_type item;
      item.cmd = cmd;
      item.push_value = value;
      req_payload <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_stack_op(item);
   endtask

   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic pause_requests(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Waits until every expected result has arrived, then lets the block settle.
   task automatic drain_results();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         $display("%0t: expected %0d more results, actual none", $time,
                  expected_results.size());
         mismatch_count++;
         expected_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [31:0] value);
      int clamped;
      drain_results();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CAPACITY_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // Out-of-range values saturate, and any write empties both stacks.
      clamped = value[CFG_W-1:0];
      if (clamped < 1) clamped = 1;
      if (clamped > MEM_DEPTH) clamped = MEM_DEPTH;
      capacity = clamped;
      depth_one = 0;
      depth_two = 0;
   endtask

   task automatic test_empty_stacks();
      send_request(CMD_POP_ONE, 32'h0);
      send_request(CMD_POP_TWO, 32'hFFFF_FFFF);
      send_request(CMD_LIST_ONE, 32'h0);
      send_request(CMD_LIST_TWO, 32'h0);
      pause_requests(2);
   endtask

   task automatic test_push_pop_list();
      send_request(CMD_PUSH_ONE, 32'h7FFF_FFFF);
      send_request(CMD_PUSH_ONE, 32'h8000_0000);
      send_request(CMD_PUSH_TWO, 32'h0000_0000);
      send_request(CMD_PUSH_TWO, 32'hFFFF_FFFF);
      send_request(CMD_PUSH_ONE, 32'h0000_0001);
      send_request(CMD_LIST_ONE, 32'h0);
      send_request(CMD_LIST_TWO, 32'h0);
      // Unused commands must produce no result.
      send_request(CMD_SPARE_LOW, $urandom());
      send_request(CMD_SPARE_HIGH, $urandom());
      send_request(CMD_POP_ONE, 32'h0);
      send_request(CMD_POP_TWO, 32'h0);
      send_request(CMD_LIST_ONE, 32'h0);
      send_request(CMD_LIST_TWO, 32'h0);
   endtask

   task automatic test_capacity_limits();
      // Stacks still hold data here; the write must empty them.
      write_capacity(32'd1);
      send_request(CMD_LIST_ONE, 32'h0);
      send_request(CMD_PUSH_TWO, 32'h1234_5678);
      send_request(CMD_PUSH_ONE, 32'h5555_5555);
      send_request(CMD_PUSH_TWO, 32'hAAAA_AAAA);
      send_request(CMD_LIST_TWO, 32'h0);
      send_request(CMD_POP_TWO, 32'h0);
      send_request(CMD_PUSH_ONE, 32'hDEAD_BEEF);
      send_request(CMD_LIST_ONE, 32'h0);
      write_capacity(32'd0);
      send_request(CMD_PUSH_ONE, 32'h0F0F_0F0F);
      send_request(CMD_PUSH_ONE, 32'hF0F0_F0F0);
      write_capacity(32'hFFFF_FFFF);
      write_capacity(32'd65);
      send_request(CMD_LIST_TWO, 32'h0);
   endtask

   task automatic test_random_traffic(int item_target);
      logic [31:0] settings [5];
      logic [31:0] value;
      logic [2:0]  cmd;
      int          pick;
      int          phase;
      int          counted;
      settings = '{32'd2, 32'd64, 32'd0, $urandom_range(3, 63), 32'd100};
      for (phase = 0; phase < 5; phase++) begin
         write_capacity(settings[phase]);
         counted = 0;
         while (counted < item_target / 5) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) cmd = CMD_PUSH_ONE;
            else if (pick < 50) cmd = CMD_PUSH_TWO;
            else if (pick < 62) cmd = CMD_POP_ONE;
            else if (pick < 74) cmd = CMD_POP_TWO;
            else if (pick < 84) cmd = CMD_LIST_ONE;
            else if (pick < 95) cmd = CMD_LIST_TWO;
            else cmd = 3'($urandom_range(CMD_SPARE_LOW, CMD_SPARE_HIGH));
            case ($urandom_range(0, 11))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'hFFFF_FFFF;
               3: value = 32'h0000_0000;
               default: value = $urandom();
            endcase
            send_request(cmd, value);
            if (cmd <= CMD_LIST_TWO) counted++;
            // The second phase runs back to back with no idle cycles.
            if (phase != 1) pause_requests(idle_cycles());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_stacks();
      test_push_pop_list();
      test_capacity_limits();
      test_random_traffic(70);
      drain_results();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/dssm_pkg.sv
design/dssm_front.sv
design/dssm_queue.sv
design/dssm_back.sv
design/dual_stack_shared_memory.sv
tb/sv/dual_stack_shared_memory_tb.sv
